FILE: rtl/swfctf_pkg.sv
`default_nettype none

package swfctf_pkg;

    // parser phases
    typedef enum logic [3:0] {
        PH_SIG     = 4'd0,
        PH_VER     = 4'd1,
        PH_LEN     = 4'd2,
        PH_RECT1   = 4'd3,
        PH_RECTN   = 4'd4,
        PH_RATE    = 4'd5,
        PH_FRAMES  = 4'd6,
        PH_TAGHDR  = 4'd7,
        PH_TAGLONG = 4'd8,
        PH_BODY    = 4'd9,
        PH_ENDED   = 4'd10,
        PH_FAILED  = 4'd11
    } phase_t;

    // result event codes
    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_TAG      = 3'd1,
        EV_END      = 3'd2,
        EV_BODY     = 3'd3,
        EV_BADSIG   = 3'd4,
        EV_BADSIZE  = 3'd5,
        EV_COMPRESS = 3'd6,
        EV_IGNORED  = 3'd7
    } event_t;

    localparam logic [7:0]  CHAR_F       = 8'h46;
    localparam logic [7:0]  CHAR_C       = 8'h43;
    localparam logic [7:0]  CHAR_W       = 8'h57;
    localparam logic [7:0]  CHAR_S       = 8'h53;
    localparam logic [5:0]  LONG_LEN_ESC = 6'h3f;
    localparam logic [16:0] RATE_ZERO    = 17'h10000;
    localparam logic [31:0] MIN_LENGTH   = 32'd8;

    // one result item
    typedef struct packed {
        logic        has_result;
        event_t      event_res;
        logic [7:0]  version;
        logic [31:0] file_length;
        logic [16:0] frame_rate;
        logic [15:0] frame_count;
        logic [9:0]  tag_code;
        logic [31:0] tag_length;
        logic        long_header;
        logic        first_tag;
        logic [7:0]  body_data;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/swf_container_tag_framer.sv
`default_nettype none

// Byte-serial framer for an uncompressed SWF container. One byte is taken per
// transfer on the s_ channel; a byte gives at most one result on the m_ channel
// (header done, tag header, end tag, body byte, an error, or ignored), and bytes
// that only feed a multi-byte field give none. Throughput is one byte per clock
// while m_ready stays high. A byte transfer lands in the input register. When
// the result register is free, the parser update and the result load happen on
// the same edge, so the result is on m_valid once its byte leaves the input
// register. While a result waits on m_ready the input register holds its byte,
// whether or not that byte gives a result. After an error or the end tag, and
// past the declared file length, every byte reports as ignored until reset.
module swf_container_tag_framer
    import swfctf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [7:0]       m_version,
    output logic [31:0]      m_file_length,
    output logic [16:0]      m_frame_rate,
    output logic [15:0]      m_frame_count,
    output logic [9:0]       m_tag_code,
    output logic [31:0]      m_tag_length,
    output logic             m_long_header,
    output logic             m_first_tag,
    output logic [7:0]       m_body_data
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       out_free;
    result_t    parse_res;
    result_t    out_res;
    phase_t     phase;

    // input stage moves on when the result slot can take whatever it produces
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    swfctf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .byte_in (in_byte_reg),
        .result  (parse_res),
        .phase   (phase)
    );

    swfctf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance && parse_res.has_result),
        .result_in  (parse_res),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .out_free   (out_free),
        .result_out (out_res)
    );

    // result fields
    assign m_event_res   = out_res.event_res;
    assign m_version     = out_res.version;
    assign m_file_length = out_res.file_length;
    assign m_frame_rate  = out_res.frame_rate;
    assign m_frame_count = out_res.frame_count;
    assign m_tag_code    = out_res.tag_code;
    assign m_tag_length  = out_res.tag_length;
    assign m_long_header = out_res.long_header;
    assign m_first_tag   = out_res.first_tag;
    assign m_body_data   = out_res.body_data;

`ifndef NO_ASSERTIONS
    // once ended, a processed byte always comes out as ignored
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase == PH_ENDED) |=> (m_valid && m_event_res == EV_IGNORED))
        else $error("byte after end tag not reported as ignored");

    // a nonzero tag code only travels on a tag header event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tag_code != '0) |-> (m_event_res == EV_TAG))
        else $error("tag code on a non-tag event");

    // the end tag carries code zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_END) |-> (m_tag_code == '0))
        else $error("end tag with nonzero code");

    // header done always carries a nonzero frame rate
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == EV_HEADER) |-> (m_frame_rate != '0))
        else $error("header event with zero frame rate");
`endif

endmodule

`default_nettype wire

FILE: rtl/swfctf_parser.sv
`default_nettype none

module swfctf_parser
    import swfctf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] byte_in,
    output result_t         result,
    output phase_t          phase
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  rect_left_reg, rect_left_next;
    logic [31:0] body_left_reg, body_left_next;
    logic [31:0] seen_reg, seen_next;
    logic [31:0] total_reg, total_next;
    logic [7:0]  version_reg, version_next;
    logic [16:0] rate_reg, rate_next;
    logic        first_reg, first_next;
    logic        compressed_reg, compressed_next;
    logic [9:0]  code_reg, code_next;

    logic [31:0] full_word;
    logic [15:0] hdr16;
    logic [5:0]  rect_sum;
    logic [4:0]  rect_cnt;
    logic [4:0]  rect_dec;
    logic        past_end;

    // field assembly helpers
    assign full_word = {byte_in, acc_reg[23:0]};
    assign hdr16     = {byte_in, acc_reg[7:0]};
    assign rect_sum  = {1'b0, byte_in[7:3]} + 6'd3;
    assign rect_cnt  = rect_sum[5:1] - 5'd1;
    assign rect_dec  = rect_left_reg - 5'd1;
    assign past_end  = (seen_reg >= total_reg);

    // next state and result for the byte being processed
    always_comb begin
        logic        do_tag;
        logic [9:0]  t_code;
        logic [31:0] t_len;
        logic        t_long;
        do_tag          = 1'b0;
        t_code          = '0;
        t_len           = '0;
        t_long          = 1'b0;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        rect_left_next  = rect_left_reg;
        body_left_next  = body_left_reg;
        seen_next       = (seen_reg == '1) ? seen_reg : seen_reg + 32'd1;
        total_next      = total_reg;
        version_next    = version_reg;
        rate_next       = rate_reg;
        first_next      = first_reg;
        compressed_next = compressed_reg;
        code_next       = code_reg;
        result          = '0;

        if (phase_reg == PH_ENDED || phase_reg == PH_FAILED) begin
            result.has_result = 1'b1;
            result.event_res  = EV_IGNORED;
        end else if (phase_reg >= PH_RECT1 && past_end) begin
            result.has_result = 1'b1;
            result.event_res  = EV_IGNORED;
        end else begin
            unique case (phase_reg)
                PH_SIG: begin
                    if (idx_reg == 2'd0) begin
                        if (byte_in != CHAR_F && byte_in != CHAR_C) begin
                            result.has_result = 1'b1;
                            result.event_res  = EV_BADSIG;
                            phase_next        = PH_FAILED;
                        end else begin
                            compressed_next = (byte_in == CHAR_C);
                            idx_next        = 2'd1;
                        end
                    end else if (idx_reg == 2'd1) begin
                        if (byte_in != CHAR_W) begin
                            result.has_result = 1'b1;
                            result.event_res  = EV_BADSIG;
                            phase_next        = PH_FAILED;
                        end else begin
                            idx_next = 2'd2;
                        end
                    end else begin
                        if (byte_in != CHAR_S) begin
                            result.has_result = 1'b1;
                            result.event_res  = EV_BADSIG;
                            phase_next        = PH_FAILED;
                        end else begin
                            idx_next   = 2'd0;
                            phase_next = PH_VER;
                        end
                    end
                end
                PH_VER: begin
                    version_next = byte_in;
                    idx_next     = 2'd0;
                    acc_next     = '0;
                    phase_next   = PH_LEN;
                end
                PH_LEN: begin
                    if (idx_reg != 2'd3) begin
                        acc_next = acc_reg | (32'(byte_in) << {idx_reg, 3'b000});
                        idx_next = idx_reg + 2'd1;
                    end else begin
                        total_next = full_word;
                        idx_next   = 2'd0;
                        acc_next   = '0;
                        if (full_word <= MIN_LENGTH || compressed_reg) begin
                            result.has_result  = 1'b1;
                            result.event_res   = (full_word <= MIN_LENGTH) ?
                                                 EV_BADSIZE : EV_COMPRESS;
                            result.version     = version_reg;
                            result.file_length = full_word;
                            phase_next         = PH_FAILED;
                        end else begin
                            phase_next = PH_RECT1;
                        end
                    end
                end
                PH_RECT1: begin
                    rect_left_next = rect_cnt;
                    phase_next     = (rect_cnt == '0) ? PH_RATE : PH_RECTN;
                end
                PH_RECTN: begin
                    rect_left_next = rect_dec;
                    if (rect_dec == '0) begin
                        phase_next = PH_RATE;
                    end
                end
                PH_RATE: begin
                    if (idx_reg == 2'd0) begin
                        acc_next = 32'(byte_in);
                        idx_next = 2'd1;
                    end else begin
                        rate_next  = (hdr16 == '0) ? RATE_ZERO : 17'(hdr16);
                        idx_next   = 2'd0;
                        acc_next   = '0;
                        phase_next = PH_FRAMES;
                    end
                end
                PH_FRAMES: begin
                    if (idx_reg == 2'd0) begin
                        acc_next = 32'(byte_in);
                        idx_next = 2'd1;
                    end else begin
                        result.has_result  = 1'b1;
                        result.event_res   = EV_HEADER;
                        result.version     = version_reg;
                        result.file_length = total_reg;
                        result.frame_rate  = rate_reg;
                        result.frame_count = hdr16;
                        idx_next           = 2'd0;
                        acc_next           = '0;
                        phase_next         = PH_TAGHDR;
                    end
                end
                PH_TAGHDR: begin
                    if (idx_reg == 2'd0) begin
                        acc_next = 32'(byte_in);
                        idx_next = 2'd1;
                    end else if (hdr16[5:0] == LONG_LEN_ESC) begin
                        code_next  = hdr16[15:6];
                        idx_next   = 2'd0;
                        acc_next   = '0;
                        phase_next = PH_TAGLONG;
                    end else begin
                        do_tag = 1'b1;
                        t_code = hdr16[15:6];
                        t_len  = 32'(hdr16[5:0]);
                        t_long = 1'b0;
                    end
                end
                PH_TAGLONG: begin
                    if (idx_reg != 2'd3) begin
                        acc_next = acc_reg | (32'(byte_in) << {idx_reg, 3'b000});
                        idx_next = idx_reg + 2'd1;
                    end else begin
                        do_tag = 1'b1;
                        t_code = code_reg;
                        t_len  = full_word;
                        t_long = 1'b1;
                    end
                end
                PH_BODY: begin
                    result.has_result = 1'b1;
                    result.event_res  = EV_BODY;
                    result.body_data  = byte_in;
                    body_left_next    = body_left_reg - 32'd1;
                    if (body_left_reg == 32'd1) begin
                        phase_next = PH_TAGHDR;
                    end
                end
                default: begin
                    result.has_result = 1'b1;
                    result.event_res  = EV_IGNORED;
                    phase_next        = PH_FAILED;
                end
            endcase

            // common tag header completion
            if (do_tag) begin
                result.has_result  = 1'b1;
                result.event_res   = (t_code == '0) ? EV_END : EV_TAG;
                result.tag_code    = t_code;
                result.tag_length  = t_len;
                result.long_header = t_long;
                result.first_tag   = first_reg;
                first_next         = 1'b0;
                idx_next           = 2'd0;
                acc_next           = '0;
                if (t_code == '0) begin
                    phase_next = PH_ENDED;
                end else if (t_len == '0) begin
                    phase_next = PH_TAGHDR;
                end else begin
                    body_left_next = t_len;
                    phase_next     = PH_BODY;
                end
            end
        end
    end

    // state registers, updated once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIG;
            idx_reg        <= '0;
            acc_reg        <= '0;
            rect_left_reg  <= '0;
            body_left_reg  <= '0;
            seen_reg       <= '0;
            total_reg      <= '0;
            version_reg    <= '0;
            rate_reg       <= '0;
            first_reg      <= 1'b1;
            compressed_reg <= 1'b0;
            code_reg       <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            acc_reg        <= acc_next;
            rect_left_reg  <= rect_left_next;
            body_left_reg  <= body_left_next;
            seen_reg       <= seen_next;
            total_reg      <= total_next;
            version_reg    <= version_next;
            rate_reg       <= rate_next;
            first_reg      <= first_next;
            compressed_reg <= compressed_next;
            code_reg       <= code_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

FILE: rtl/swfctf_out_reg.sv
`default_nettype none

module swfctf_out_reg
    import swfctf_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t result_in,
    input  wire logic    m_ready,
    output logic         m_valid,
    output logic         out_free,
    output result_t      result_out
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // slot can take a new result when empty or being drained this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds while a transfer is pending
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire
